>>> src/stc_pkg.sv
// Shared types, widths and arithmetic helpers of the segment-triangle intersection block.
`default_nettype none
package stc_pkg;

    localparam int CW           = 16;
    localparam int EW           = CW + 1;
    localparam int CPW          = 2 * EW + 1;
    localparam int MW           = CPW + EW;
    localparam int DW           = MW + 2;
    localparam int LW           = DW / 2;
    localparam int HW           = DW - LW;
    localparam int PRW          = DW + EW;
    localparam int QW           = CW;
    localparam int THRW         = 40;
    localparam int QDEPTH       = 4;
    localparam int QAW          = 2;
    localparam int NUM_VERTS    = 3;
    localparam int BACK_STAGES  = 8 + QW;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_TEST  = 1'b1;

    typedef struct packed {
        logic          kind;
        logic [1:0]    vertex_index;
        logic [CW-1:0] first_x;
        logic [CW-1:0] first_y;
        logic [CW-1:0] first_z;
        logic [CW-1:0] second_x;
        logic [CW-1:0] second_y;
        logic [CW-1:0] second_z;
    } t_item;

    typedef struct packed {
        logic          hit;
        logic [CW-1:0] point_x;
        logic [CW-1:0] point_y;
        logic [CW-1:0] point_z;
    } t_result;

    typedef struct packed {
        logic [2:0][CW-1:0] s;
        logic [2:0][EW-1:0] d;
        logic [2:0][EW-1:0] e1;
        logic [2:0][EW-1:0] e2;
        logic [2:0][EW-1:0] t;
    } t_task;

    function automatic logic [EW-1:0] f_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
        return {a[CW-1], a} - {b[CW-1], b};
    endfunction

    function automatic logic [2*EW-1:0] f_mul_ee(input logic [EW-1:0] a,
                                                 input logic [EW-1:0] b);
        logic signed [2*EW-1:0] r;
        r = $signed(a) * $signed(b);
        return r;
    endfunction

    function automatic logic [CPW-1:0] f_sub_c(input logic [2*EW-1:0] a,
                                               input logic [2*EW-1:0] b);
        return {a[2*EW-1], a} - {b[2*EW-1], b};
    endfunction

    function automatic logic [MW-1:0] f_mul_ce(input logic [CPW-1:0] a,
                                               input logic [EW-1:0] b);
        logic signed [MW-1:0] r;
        r = $signed(a) * $signed(b);
        return r;
    endfunction

    function automatic logic [DW-1:0] f_sum3(input logic [MW-1:0] a, input logic [MW-1:0] b,
                                             input logic [MW-1:0] c);
        logic signed [DW-1:0] r;
        r = $signed(a) + $signed(b) + $signed(c);
        return r;
    endfunction

endpackage
`default_nettype wire

>>> src/stc_front.sv
// Front end: takes transactions, stores triangle vertices, forms edges of each test.
`default_nettype none
module stc_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire stc_pkg::t_item i_in_data,
    input  wire logic           i_full,
    output logic                o_push,
    output stc_pkg::t_task      o_task
);
    import stc_pkg::*;

    logic [2:0][2:0][CW-1:0] r_vtx;
    logic [2:0][CW-1:0]      w_s;
    logic [2:0][CW-1:0]      w_e;
    logic                    w_acc;

    assign o_in_ready = !i_full;
    assign w_acc      = i_in_valid && o_in_ready;
    assign o_push     = w_acc && (i_in_data.kind == KIND_TEST);
    assign w_s        = {i_in_data.first_z, i_in_data.first_y, i_in_data.first_x};
    assign w_e        = {i_in_data.second_z, i_in_data.second_y, i_in_data.second_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vtx <= '0;
        end else if (w_acc && (i_in_data.kind == KIND_LOAD) &&
                     (i_in_data.vertex_index < 2'(NUM_VERTS))) begin
            r_vtx[i_in_data.vertex_index] <= w_s;
        end
    end

    always_comb begin
        o_task.s = w_s;
        for (int k = 0; k < 3; k++) begin
            o_task.d[k]  = f_diff(w_e[k], w_s[k]);
            o_task.e1[k] = f_diff(r_vtx[1][k], r_vtx[0][k]);
            o_task.e2[k] = f_diff(r_vtx[2][k], r_vtx[0][k]);
            o_task.t[k]  = f_diff(w_s[k], r_vtx[0][k]);
        end
    end

endmodule
`default_nettype wire

>>> src/stc_queue.sv
// Short queue of pending segment tests between front and back.
`default_nettype none
module stc_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire stc_pkg::t_task i_data,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_empty,
    output stc_pkg::t_task      o_data
);
    import stc_pkg::*;

    t_task            r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr;
    logic [QAW-1:0]   r_rd;
    logic [QAW:0]     r_cnt;
    logic [QAW:0]     n_cnt;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("pop from empty queue");
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0 && r_cnt != (QAW+1)'(QDEPTH)) |-> (r_wr - r_rd) == r_cnt[QAW-1:0])
        else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

>>> src/stc_back.sv
// Back end: pipelined cross products, determinant tests and point division.
`default_nettype none
module stc_back (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_empty,
    output logic                        o_pop,
    input  wire stc_pkg::t_task         i_task,
    input  wire logic [stc_pkg::THRW-1:0] i_thr,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output stc_pkg::t_result            o_data
);
    import stc_pkg::*;

    typedef struct packed {
        logic                hit;
        logic [DW-1:0]       det;
        logic [2:0][CW-1:0]  s;
        logic [2:0]          dneg;
        logic [2:0][PRW-1:0] rem;
        logic [2:0][QW-1:0]  q;
    } t_div;

    logic                    w_adv;
    logic [BACK_STAGES-1:0]  r_vld;
    logic                    r_ovld;
    t_result                 r_out;
    t_result                 n_out;

    logic [2:0][CW-1:0]      r1_s;
    logic [2:0][EW-1:0]      r1_d, r1_e1, r1_e2, r1_t;
    logic [2:0][2*EW-1:0]    r1_pa, r1_pb, r1_qa, r1_qb;

    logic [2:0][CW-1:0]      r2_s;
    logic [2:0][EW-1:0]      r2_d, r2_e1, r2_e2, r2_t;
    logic [2:0][CPW-1:0]     r2_p, r2_q;

    logic [2:0][CW-1:0]      r3_s;
    logic [2:0][EW-1:0]      r3_d;
    logic [2:0][MW-1:0]      r3_pe, r3_tp, r3_dq, r3_eq;

    logic [2:0][CW-1:0]      r4_s;
    logic [2:0][EW-1:0]      r4_d;
    logic [DW-1:0]           r4_det, r4_u, r4_v, r4_tn;

    logic [2:0][CW-1:0]      r5_s;
    logic [2:0][EW-1:0]      r5_d;
    logic [DW-1:0]           r5_det, r5_u, r5_v, r5_tn;

    logic [2:0][CW-1:0]      r6_s;
    logic [2:0][EW-1:0]      r6_d;
    logic [DW-1:0]           r6_det, r6_tn;
    logic                    r6_hit;

    logic [2:0][CW-1:0]      r7_s;
    logic [2:0]              r7_dneg;
    logic [DW-1:0]           r7_det;
    logic                    r7_hit;
    logic [2:0][LW+EW-1:0]   r7_lo;
    logic [2:0][HW+EW-1:0]   r7_hi;

    t_div                    r_dv [QW+1];

    logic                    w_neg;
    logic [DW+1:0]           w_du, w_dv, w_duv, w_dt;
    logic                    w_par;
    logic [2:0][EW-1:0]      w_md;

    assign w_adv   = !r_ovld || i_ready;
    assign o_pop   = w_adv && !i_empty;
    assign o_valid = r_ovld;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else if (w_adv) begin
            r_vld  <= {r_vld[BACK_STAGES-2:0], o_pop};
            r_ovld <= r_vld[BACK_STAGES-1];
        end
    end

    assign w_neg = r4_det[DW-1];
    assign w_par = (r5_det <= DW'(i_thr));
    assign w_du  = {{2{r5_det[DW-1]}}, r5_det} - {{2{r5_u[DW-1]}}, r5_u};
    assign w_dv  = {{2{r5_det[DW-1]}}, r5_det} - {{2{r5_v[DW-1]}}, r5_v};
    assign w_duv = w_du - {{2{r5_v[DW-1]}}, r5_v};
    assign w_dt  = {{2{r5_det[DW-1]}}, r5_det} - {{2{r5_tn[DW-1]}}, r5_tn};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_md[k] = r6_d[k][EW-1] ? (EW'(0) - r6_d[k]) : r6_d[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_s  <= i_task.s;
            r1_d  <= i_task.d;
            r1_e1 <= i_task.e1;
            r1_e2 <= i_task.e2;
            r1_t  <= i_task.t;
            for (int k = 0; k < 3; k++) begin
                r1_pa[k] <= f_mul_ee(i_task.d[(k+1)%3], i_task.e2[(k+2)%3]);
                r1_pb[k] <= f_mul_ee(i_task.d[(k+2)%3], i_task.e2[(k+1)%3]);
                r1_qa[k] <= f_mul_ee(i_task.t[(k+1)%3], i_task.e1[(k+2)%3]);
                r1_qb[k] <= f_mul_ee(i_task.t[(k+2)%3], i_task.e1[(k+1)%3]);
            end

            r2_s  <= r1_s;
            r2_d  <= r1_d;
            r2_e1 <= r1_e1;
            r2_e2 <= r1_e2;
            r2_t  <= r1_t;
            for (int k = 0; k < 3; k++) begin
                r2_p[k] <= f_sub_c(r1_pa[k], r1_pb[k]);
                r2_q[k] <= f_sub_c(r1_qa[k], r1_qb[k]);
            end

            r3_s <= r2_s;
            r3_d <= r2_d;
            for (int k = 0; k < 3; k++) begin
                r3_pe[k] <= f_mul_ce(r2_p[k], r2_e1[k]);
                r3_tp[k] <= f_mul_ce(r2_p[k], r2_t[k]);
                r3_dq[k] <= f_mul_ce(r2_q[k], r2_d[k]);
                r3_eq[k] <= f_mul_ce(r2_q[k], r2_e2[k]);
            end

            r4_s   <= r3_s;
            r4_d   <= r3_d;
            r4_det <= f_sum3(r3_pe[0], r3_pe[1], r3_pe[2]);
            r4_u   <= f_sum3(r3_tp[0], r3_tp[1], r3_tp[2]);
            r4_v   <= f_sum3(r3_dq[0], r3_dq[1], r3_dq[2]);
            r4_tn  <= f_sum3(r3_eq[0], r3_eq[1], r3_eq[2]);

            r5_s   <= r4_s;
            r5_d   <= r4_d;
            r5_det <= w_neg ? (DW'(0) - r4_det) : r4_det;
            r5_u   <= w_neg ? (DW'(0) - r4_u)   : r4_u;
            r5_v   <= w_neg ? (DW'(0) - r4_v)   : r4_v;
            r5_tn  <= w_neg ? (DW'(0) - r4_tn)  : r4_tn;

            r6_s   <= r5_s;
            r6_d   <= r5_d;
            r6_det <= r5_det;
            r6_tn  <= r5_tn;
            r6_hit <= !w_par && !r5_u[DW-1] && !w_du[DW+1] && !r5_v[DW-1] && !w_dv[DW+1] &&
                      !w_duv[DW+1] && !r5_tn[DW-1] && !w_dt[DW+1];

            r7_s   <= r6_s;
            r7_det <= r6_det;
            r7_hit <= r6_hit;
            for (int k = 0; k < 3; k++) begin
                r7_dneg[k] <= r6_d[k][EW-1];
                r7_lo[k]   <= (LW+EW)'(r6_tn[LW-1:0]) * (LW+EW)'(w_md[k]);
                r7_hi[k]   <= (HW+EW)'(r6_tn[DW-1:LW]) * (HW+EW)'(w_md[k]);
            end

            r_dv[0].hit  <= r7_hit;
            r_dv[0].det  <= r7_det;
            r_dv[0].s    <= r7_s;
            r_dv[0].dneg <= r7_dneg;
            r_dv[0].q    <= '0;
            for (int k = 0; k < 3; k++) begin
                r_dv[0].rem[k] <= PRW'(r7_lo[k]) + (PRW'(r7_hi[k]) << LW);
            end
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_div
        localparam int B = QW - 1 - j;
        t_div          w_nx;
        logic [PRW-1:0] w_dsh;

        always_comb begin
            w_nx  = r_dv[j];
            w_dsh = PRW'(r_dv[j].det) << B;
            for (int k = 0; k < 3; k++) begin
                if (r_dv[j].rem[k] >= w_dsh) begin
                    w_nx.rem[k] = r_dv[j].rem[k] - w_dsh;
                    w_nx.q[k]   = r_dv[j].q[k] | (QW'(1) << B);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dv[j+1] <= w_nx;
            end
        end
    end

    always_comb begin
        logic [2:0][CW-1:0] pt;
        for (int k = 0; k < 3; k++) begin
            pt[k] = r_dv[QW].dneg[k] ? (r_dv[QW].s[k] - r_dv[QW].q[k])
                                     : (r_dv[QW].s[k] + r_dv[QW].q[k]);
            if (!r_dv[QW].hit) begin
                pt[k] = '0;
            end
        end
        n_out.hit     = r_dv[QW].hit;
        n_out.point_x = pt[0];
        n_out.point_y = pt[1];
        n_out.point_z = pt[2];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && !r_out.hit) |-> (r_out.point_x == '0 && r_out.point_y == '0 &&
                                    r_out.point_z == '0))
        else $error("miss carries a nonzero point");
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && !i_ready) |=> (r_ovld && $stable(r_out)))
        else $error("stalled result lost");

endmodule
`default_nettype wire

>>> src/segment_triangle_intersect.sv
// Top level of the segment-triangle intersection block.
//
//  channel   signals                           direction  payload
//  in        i_in_valid / o_in_ready           in         t_item
//  out       o_out_valid / i_out_ready         out        t_result
//  cfg       i_cfg_valid / o_cfg_ready         in         parallel threshold, 40 bits
//
//  One transaction per cycle sustained while the output is not stalled; a test result
//  passes the queue, the 8-stage product pipeline, the 16-stage quotient divider
//  and the output register.
//  Loads give no result. Reset is synchronous and active low.
//  A stalled output holds the back pipeline; the 4-entry queue then fills and drops
//  o_in_ready.
`default_nettype none
module segment_triangle_intersect (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire stc_pkg::t_item         i_in_data,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output stc_pkg::t_result            o_out_data,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [stc_pkg::THRW-1:0] i_cfg_data
);
    import stc_pkg::*;

    logic [THRW-1:0] r_thr;
    logic            w_push, w_full, w_pop, w_empty;
    t_task           w_task_in, w_task_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    stc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_task     (w_task_in)
    );

    stc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_task_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_task_out)
    );

    stc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .i_task  (w_task_out),
        .i_thr   (r_thr),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule
`default_nettype wire

>>> sim/tb_segment_triangle_intersect.sv
// Testbench of the segment-triangle intersection block: directed table, random segments, scoreboard.
`default_nettype none
module tb_segment_triangle_intersect;
    timeunit 1ns;
    timeprecision 1ps;
    import stc_pkg::*;

    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        t_item   item;
        logic    has_golden;
        t_result golden;
    } t_row;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_in_valid = 1'b0;
    logic          o_in_ready;
    t_item         i_in_data = '0;
    logic          o_out_valid;
    logic          i_out_ready = 1'b0;
    t_result       o_out_data;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [THRW-1:0] i_cfg_data = '0;

    always #5 i_clk = ~i_clk;

    segment_triangle_intersect u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    // model state
    logic signed [CW-1:0] tri_vert [9];
    logic [THRW-1:0]      threshold;

    t_result hit_queue [$];
    int      mismatches = 0;
    int      tests_sent = 0;
    int      loads_sent = 0;
    int      hits_seen = 0;
    int      results_seen = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    logic    hold_off = 1'b0;

    function automatic t_result predict_segment(input t_item it);
        logic signed [127:0] s[3], d[3], v0[3], e1[3], e2[3], tv[3], p[3], q[3];
        logic signed [127:0] det, un, vn, tn, md, mq;
        t_result r;
        s[0] = $signed(it.first_x);  s[1] = $signed(it.first_y);  s[2] = $signed(it.first_z);
        d[0] = $signed(it.second_x) - s[0];
        d[1] = $signed(it.second_y) - s[1];
        d[2] = $signed(it.second_z) - s[2];
        for (int k = 0; k < 3; k++) begin
            v0[k] = tri_vert[k];
            e1[k] = 128'(tri_vert[3+k]) - v0[k];
            e2[k] = 128'(tri_vert[6+k]) - v0[k];
            tv[k] = s[k] - v0[k];
        end
        p[0] = d[1]*e2[2] - d[2]*e2[1];
        p[1] = d[2]*e2[0] - d[0]*e2[2];
        p[2] = d[0]*e2[1] - d[1]*e2[0];
        q[0] = tv[1]*e1[2] - tv[2]*e1[1];
        q[1] = tv[2]*e1[0] - tv[0]*e1[2];
        q[2] = tv[0]*e1[1] - tv[1]*e1[0];
        det = p[0]*e1[0] + p[1]*e1[1] + p[2]*e1[2];
        un = tv[0]*p[0] + tv[1]*p[1] + tv[2]*p[2];
        vn = d[0]*q[0] + d[1]*q[1] + d[2]*q[2];
        tn = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
        if (det < 0) begin
            det = -det; un = -un; vn = -vn; tn = -tn;
        end
        r = '0;
        if (det <= $signed({88'd0, threshold})) return r;
        if (un < 0 || un > det || vn < 0 || vn > det || un + vn > det) return r;
        if (tn < 0 || tn > det) return r;
        r.hit = 1'b1;
        for (int k = 0; k < 3; k++) begin
            md = d[k] < 0 ? -d[k] : d[k];
            mq = (tn * md) / det;
            if (k == 0) r.point_x = CW'(d[k] < 0 ? s[k] - mq : s[k] + mq);
            if (k == 1) r.point_y = CW'(d[k] < 0 ? s[k] - mq : s[k] + mq);
            if (k == 2) r.point_z = CW'(d[k] < 0 ? s[k] - mq : s[k] + mq);
        end
        return r;
    endfunction

    task automatic send_item(input t_item it, input logic has_golden, input t_result golden);
        t_result pr;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (it.kind == KIND_LOAD) begin
            loads_sent++;
            if (it.vertex_index != 2'd3) begin
                tri_vert[it.vertex_index*3]   = it.first_x;
                tri_vert[it.vertex_index*3+1] = it.first_y;
                tri_vert[it.vertex_index*3+2] = it.first_z;
            end
        end else begin
            pr = predict_segment(it);
            if (has_golden && pr !== golden) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("typed-in result differs from prediction: %h vs %h", golden, pr);
            end
            hit_queue.push_back(pr);
            tests_sent++;
        end
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (hit_queue.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_threshold(input logic [THRW-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        threshold = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_item make_load(input logic [1:0] idx, input logic [CW-1:0] x,
                                        input logic [CW-1:0] y, input logic [CW-1:0] z);
        t_item it;
        it = '0;
        it.kind = KIND_LOAD; it.vertex_index = idx;
        it.first_x = x; it.first_y = y; it.first_z = z;
        it.second_x = CW'($urandom); it.second_y = CW'($urandom); it.second_z = CW'($urandom);
        return it;
    endfunction

    function automatic t_item make_test(input logic [CW-1:0] sx, input logic [CW-1:0] sy,
                                        input logic [CW-1:0] sz, input logic [CW-1:0] ex,
                                        input logic [CW-1:0] ey, input logic [CW-1:0] ez);
        t_item it;
        it.kind = KIND_TEST; it.vertex_index = 2'($urandom);
        it.first_x = sx; it.first_y = sy; it.first_z = sz;
        it.second_x = ex; it.second_y = ey; it.second_z = ez;
        return it;
    endfunction

    function automatic logic [CW-1:0] rand_coord(input int span);
        return CW'($signed($urandom_range(2*span)) - span);
    endfunction

    // receiver
    always @(negedge i_clk) begin
        if (hold_off) i_out_ready <= 1'b0;
        else i_out_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (hit_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", o_out_data);
            end else begin
                if (o_out_data.hit) hits_seen++;
                if (o_out_data !== hit_queue[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected hit=%b p=(%h,%h,%h) got hit=%b p=(%h,%h,%h)",
                                 hit_queue[0].hit, hit_queue[0].point_x, hit_queue[0].point_y,
                                 hit_queue[0].point_z, o_out_data.hit, o_out_data.point_x,
                                 o_out_data.point_y, o_out_data.point_z);
                end
                void'(hit_queue.pop_front());
            end
        end
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        t_row    rows [$];
        t_row    rw;
        t_item   it;
        t_result none;
        int      span;
        none = '0;
        for (int k = 0; k < 9; k++) tri_vert[k] = '0;
        threshold = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table: unloaded triangle, loads, extremes, ignored index
        rw.has_golden = 1'b1; rw.golden = none;
        rw.item = make_test(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff);
        rows.push_back(rw);
        rw.has_golden = 1'b0;
        rw.item = make_load(2'd0, 16'd0, 16'd0, 16'd0);       rows.push_back(rw);
        rw.item = make_load(2'd1, 16'd640, 16'd0, 16'd0);     rows.push_back(rw);
        rw.item = make_load(2'd2, 16'd0, 16'd640, 16'd0);     rows.push_back(rw);
        rw.item = make_test(16'd64, 16'd64, 16'hffc0, 16'd64, 16'd64, 16'd64);   rows.push_back(rw);
        rw.item = make_test(16'd64, 16'd64, 16'h8000, 16'd64, 16'd64, 16'h7fff); rows.push_back(rw);
        rw.item = make_test(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd64);          rows.push_back(rw);
        rw.item = make_test(16'd640, 16'd0, 16'd64, 16'd640, 16'd0, 16'hffc0);   rows.push_back(rw);
        rw.item = make_test(16'd320, 16'd320, 16'd64, 16'd320, 16'd320, 16'hff00); rows.push_back(rw);
        rw.item = make_test(16'd0, 16'd0, 16'd64, 16'd0, 16'd0, 16'd128);        rows.push_back(rw);
        rw.item = make_test(16'd900, 16'd900, 16'd64, 16'd900, 16'd900, 16'hffc0); rows.push_back(rw);
        rw.item = make_test(16'd64, 16'd64, 16'd0, 16'd64, 16'd64, 16'd0);       rows.push_back(rw);
        rw.item = make_test(16'hffff, 16'd64, 16'd64, 16'hffff, 16'd64, 16'hffc0); rows.push_back(rw);
        rw.item = make_load(2'd3, 16'h7fff, 16'h7fff, 16'h7fff); rows.push_back(rw);
        rw.item = make_test(16'd100, 16'd100, 16'd64, 16'd100, 16'd100, 16'hffc0); rows.push_back(rw);
        rw.item = make_load(2'd0, 16'h8000, 16'h8000, 16'h8000); rows.push_back(rw);
        rw.item = make_load(2'd1, 16'h7fff, 16'h8000, 16'h8000); rows.push_back(rw);
        rw.item = make_load(2'd2, 16'h8000, 16'h7fff, 16'h7fff); rows.push_back(rw);
        rw.item = make_test(16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h7fff);
        rows.push_back(rw);
        rw.item = make_test(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000);
        rows.push_back(rw);
        rw.item = make_load(2'd1, 16'h8000, 16'h8000, 16'h8000); rows.push_back(rw);
        rw.has_golden = 1'b1;
        rw.item = make_test(16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6); rows.push_back(rw);
        foreach (rows[i]) send_item(rows[i].item, rows[i].has_golden, rows[i].golden);

        // random phases, each setting a threshold and an idle mix
        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            case (ph)
                0: write_threshold('0);
                1: write_threshold(40'd1000);
                2: write_threshold(40'(($urandom % 64) << 18));
                3: write_threshold({THRW{1'b1}});
                4: write_threshold(40'd4095);
                default: write_threshold('0);
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            if (ph == 5) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (200) @(negedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < 220; n++) begin
                if (n % 40 == 0) begin
                    span = ($urandom_range(3) == 0) ? 32767 : 2000;
                    for (int v = 0; v < 3; v++) begin
                        it = make_load(2'(v), rand_coord(span), rand_coord(span),
                                       rand_coord(span));
                        send_item(it, 1'b0, none);
                    end
                end
                case ($urandom_range(9))
                    0: it = make_load(2'($urandom), CW'($urandom), CW'($urandom),
                                      CW'($urandom));
                    1: it = make_test(CW'($urandom), CW'($urandom), CW'($urandom),
                                      CW'($urandom), CW'($urandom), CW'($urandom));
                    default: begin
                        // segment across the triangle's plane near its vertices
                        it = make_test(
                            CW'(tri_vert[$urandom_range(2)*3] / 2 + tri_vert[0] / 2
                                + $signed($urandom_range(200)) - 100),
                            CW'(tri_vert[$urandom_range(2)*3+1] / 2 + tri_vert[1] / 2
                                + $signed($urandom_range(200)) - 100),
                            CW'(tri_vert[2] + $signed($urandom_range(4000))),
                            CW'(tri_vert[$urandom_range(2)*3] / 2 + tri_vert[3] / 2
                                + $signed($urandom_range(200)) - 100),
                            CW'(tri_vert[$urandom_range(2)*3+1] / 2 + tri_vert[7] / 2
                                + $signed($urandom_range(200)) - 100),
                            CW'(tri_vert[8] - $signed($urandom_range(4000))));
                    end
                endcase
                send_item(it, 1'b0, none);
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_idle();

        $display("Covered %0d loads and %0d segment tests, %0d results with %0d hits,",
                 loads_sent, tests_sent, results_seen, hits_seen);
        $display("over six threshold settings, idle mixes and one long output hold-off.");
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> sim.f
src/stc_pkg.sv
src/stc_front.sv
src/stc_queue.sv
src/stc_back.sv
src/segment_triangle_intersect.sv
sim/tb_segment_triangle_intersect.sv
